// ===== design/tbo_pkg.sv =====
// ============================================================================
// tbo_pkg
// Shared types and constants for the transformed box overlap test.
// ============================================================================
package tbo_pkg;

    // width of one transform row sum, wide enough for two truncated products
    // plus the translation term at any supported fraction width
    localparam int RowW = 66;

    typedef logic [2:0] t_op;

    localparam t_op OP_BOX  = 3'd0;
    localparam t_op OP_ROWX = 3'd1;
    localparam t_op OP_ROWY = 3'd2;
    localparam t_op OP_ROWW = 3'd3;
    localparam t_op OP_TEST = 3'd4;

    typedef struct packed {
        t_op                op;
        logic signed [31:0] a;
        logic signed [31:0] b;
        logic signed [31:0] c;
        logic signed [31:0] d;
    } t_item;

    // handshake toward the shared divider
    typedef struct packed {
        logic                   start;
        logic signed [RowW-1:0] num;
        logic signed [RowW-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic               done;
        logic signed [31:0] q;
    } t_div_rsp;

endpackage

// ===== design/transformed_box_overlap_test.sv =====
// ============================================================================
// transformed_box_overlap_test
// Projective box transform followed by an overlap test against a stored box.
// ============================================================================
// Input channel: drive i_func and the four words, raise push; the word is
// taken on a clock edge where full is low. Func 0 loads the reference box,
// funcs 1 to 3 load the x, y and w transform rows, func 4 runs a test, and
// funcs 5 to 7 are dropped. Only a test gives a result.
// Result channel: while empty is low, o_hit and o_fault show the oldest
// result; raise pop to take it. A held result does not stop the engine
// from starting the next item; it waits only when a new result is ready.
// Timing: a load is applied as the engine takes it. A test runs its 4
// corners in turn, each through the multiply steps, a check, two divides
// through the shared restoring divider and a step state, and the engine
// takes no new item until its result is written. The divider sets the
// throughput; a corner with zero w skips its divides.
// A two-entry queue sits in front of the engine, so up to two words are
// accepted while a test runs.
// Reset: the reference box clears, the transform returns to identity and
// both queues empty.
// ============================================================================
module transformed_box_overlap_test #(
    parameter int FRAC_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  logic [2:0]         i_func,
    input  logic signed [31:0] i_word_a,
    input  logic signed [31:0] i_word_b,
    input  logic signed [31:0] i_word_c,
    input  logic signed [31:0] i_word_d,
    output logic               empty,
    input  logic               pop,
    output logic               o_hit,
    output logic               o_fault
);
    import tbo_pkg::*;

    logic     w_valid;
    t_item    w_item;
    logic     w_pop;
    t_div_req w_req;
    t_div_rsp w_rsp;
    logic     w_res_v;

    tbo_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_func   (i_func),
        .i_word_a (i_word_a),
        .i_word_b (i_word_b),
        .i_word_c (i_word_c),
        .i_word_d (i_word_d),
        .o_full   (full),
        .o_valid  (w_valid),
        .o_item   (w_item),
        .i_pop    (w_pop)
    );

    tbo_back #(.FRAC_BITS(FRAC_BITS)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (w_valid),
        .i_item      (w_item),
        .o_pop       (w_pop),
        .o_div       (w_req),
        .i_div       (w_rsp),
        .o_res_valid (w_res_v),
        .o_hit       (o_hit),
        .o_fault     (o_fault),
        .i_res_pop   (pop)
    );

    tbo_div #(.FRAC_BITS(FRAC_BITS)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    assign empty = !w_res_v;

    a_hit_fault_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> !(o_hit && o_fault))
        else $error("hit and fault both set");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> (empty && !full))
        else $error("queues not empty after reset");

endmodule

// ===== design/tbo_front.sv =====
// ============================================================================
// tbo_front
// Accepts input words, drops unused function codes and holds the rest in a
// two-entry queue toward the execution engine.
// ============================================================================
module tbo_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  logic [2:0]         i_func,
    input  logic signed [31:0] i_word_a,
    input  logic signed [31:0] i_word_b,
    input  logic signed [31:0] i_word_c,
    input  logic signed [31:0] i_word_d,
    output logic               o_full,
    output logic               o_valid,
    output tbo_pkg::t_item     o_item,
    input  logic               i_pop
);
    import tbo_pkg::*;

    t_item      r_q [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       w_acc;
    logic       w_keep;
    logic       w_pop;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_item  = r_q[r_rp];
    assign w_acc   = i_push && !o_full;
    // codes above the test code change nothing: drop them here
    assign w_keep  = w_acc && (i_func <= OP_TEST);
    assign w_pop   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (w_keep) begin
            r_q[r_wp] <= '{op: i_func, a: i_word_a, b: i_word_b,
                           c: i_word_c, d: i_word_d};
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_keep) r_wp <= ~r_wp;
            if (w_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, w_keep} - {1'b0, w_pop};
        end
    end

endmodule

// ===== design/tbo_div.sv =====
// ============================================================================
// tbo_div
// Restoring divider: q = num * 2^FRAC_BITS / den, rounded toward zero and
// saturated to 32 bits. A load step, then one quotient bit per cycle;
// the quotient shows on o_rsp with done once the last bit is in.
// ============================================================================
module tbo_div #(
    parameter int FRAC_BITS = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  tbo_pkg::t_div_req i_req,
    output tbo_pkg::t_div_rsp o_rsp
);
    import tbo_pkg::*;

    localparam int NW = RowW + FRAC_BITS;
    localparam int CW = RowW + 1;

    logic [RowW-1:0]   w_nmag;
    logic [RowW-1:0]   w_dmag;
    logic [NW-1:0]     w_n;
    logic [CW-1:0]     w_top;
    logic [CW-1:0]     w_sh;
    logic              w_ge;
    logic [CW-1:0]     w_rem;
    logic [31:0]       w_qn;
    logic signed [31:0] w_qfin;

    logic [CW-1:0]     r_rem;
    logic [31:0]       r_low;
    logic [RowW-1:0]   r_d;
    logic [31:0]       r_q;
    logic [4:0]        r_cnt;
    logic              r_run;
    logic              r_neg;
    logic              r_sat;
    logic              r_done;
    logic signed [31:0] r_qout;

    assign w_nmag = i_req.num[RowW-1] ? RowW'(-i_req.num) : RowW'(i_req.num);
    assign w_dmag = i_req.den[RowW-1] ? RowW'(-i_req.den) : RowW'(i_req.den);
    assign w_n    = NW'(w_nmag) << FRAC_BITS;
    assign w_top  = CW'(w_n >> 32);

    assign w_sh  = {r_rem[CW-2:0], r_low[31]};
    assign w_ge  = (w_sh >= CW'(r_d));
    assign w_rem = w_ge ? (w_sh - CW'(r_d)) : w_sh;
    assign w_qn  = {r_q[30:0], w_ge};

    always_comb begin
        if (r_neg) begin
            if (r_sat || (w_qn > 32'h8000_0000)) w_qfin = 32'sh8000_0000;
            else                                 w_qfin = -$signed(w_qn);
        end else begin
            if (r_sat || w_qn[31]) w_qfin = 32'sh7FFF_FFFF;
            else                   w_qfin = $signed(w_qn);
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.q    = r_qout;

    always_ff @(posedge i_clk) begin
        if (i_req.start && !r_run) begin
            r_rem <= w_top;
            r_low <= w_n[31:0];
            r_d   <= w_dmag;
            r_q   <= 32'd0;
            r_neg <= i_req.num[RowW-1] ^ i_req.den[RowW-1];
            // quotient of 2^32 or more: saturate whatever the low bits say
            r_sat <= (w_top >= CW'(w_dmag));
        end else if (r_run) begin
            r_rem <= w_rem;
            r_low <= {r_low[30:0], 1'b0};
            r_q   <= w_qn;
            if (r_cnt == 5'd31) r_qout <= w_qfin;
        end
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_cnt  <= 5'd0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start && !r_run) begin
                r_run <= 1'b1;
                r_cnt <= 5'd0;
            end else if (r_run) begin
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

endmodule

// ===== design/tbo_back.sv =====
// ============================================================================
// tbo_back
// Execution engine: applies operand loads and runs box tests corner by
// corner through one multiplier and the shared divider.
// ============================================================================
module tbo_back #(
    parameter int FRAC_BITS = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  tbo_pkg::t_item    i_item,
    output logic              o_pop,
    output tbo_pkg::t_div_req o_div,
    input  tbo_pkg::t_div_rsp i_div,
    output logic              o_res_valid,
    output logic              o_hit,
    output logic              o_fault,
    input  logic              i_res_pop
);
    import tbo_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL  = 3'd1;
    localparam logic [2:0] S_CHK  = 3'd2;
    localparam logic [2:0] S_DX   = 3'd3;
    localparam logic [2:0] S_DY   = 3'd4;
    localparam logic [2:0] S_NEXT = 3'd5;
    localparam logic [2:0] S_FIN  = 3'd6;

    localparam logic signed [31:0] One = 32'sd1 <<< FRAC_BITS;

    function automatic logic signed [31:0] sat33(input logic signed [32:0] v);
        if (v[32] != v[31]) return v[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        return v[31:0];
    endfunction

    function automatic logic meet(input logic signed [33:0] lo0,
                                  input logic signed [33:0] hi0,
                                  input logic signed [33:0] b0,
                                  input logic signed [33:0] b1);
        logic signed [33:0] blo;
        logic signed [33:0] bhi;
        logic signed [33:0] lo;
        logic signed [33:0] hi;
        blo = (b0 > b1) ? b1 : b0;
        bhi = (b0 > b1) ? b0 : b1;
        lo  = (lo0 > blo) ? lo0 : blo;
        hi  = (hi0 < bhi) ? hi0 : bhi;
        return lo <= hi;
    endfunction

    logic [2:0]             r_state;
    logic signed [31:0]     r_ref  [4];
    logic signed [31:0]     r_rows [9];
    logic signed [31:0]     r_xs   [2];
    logic signed [31:0]     r_ys   [2];
    logic signed [RowW-1:0] r_acc  [3];
    logic signed [63:0]     r_prod;
    logic [2:0]             r_cnt;
    logic [1:0]             r_corner;
    logic                   r_first;
    logic                   r_flt;
    logic signed [31:0]     r_qx;
    logic signed [31:0]     r_minx;
    logic signed [31:0]     r_maxx;
    logic signed [31:0]     r_miny;
    logic signed [31:0]     r_maxy;
    logic                   r_res_v;
    logic                   r_hit;
    logic                   r_fault;

    logic [1:0]             w_row;
    logic                   w_col;
    logic [3:0]             w_ci;
    logic signed [31:0]     w_coef;
    logic signed [31:0]     w_coord;
    logic signed [63:0]     w_prod;
    logic [2:0]             w_pm;
    logic [1:0]             w_prow;
    logic signed [RowW-1:0] w_pext;
    logic signed [32:0]     w_ax;
    logic signed [32:0]     w_ay;
    logic signed [32:0]     w_cx;
    logic signed [32:0]     w_dy;
    logic signed [33:0]     w_rlx;
    logic signed [33:0]     w_rhx;
    logic signed [33:0]     w_rly;
    logic signed [33:0]     w_rhy;
    logic                   w_hit;
    logic                   w_free;

    assign w_row   = r_cnt[2:1];
    assign w_col   = r_cnt[0];
    assign w_ci    = {1'b0, w_row, 1'b0} + {2'b00, w_row} + {3'b000, w_col};
    assign w_coef  = r_rows[w_ci];
    assign w_coord = w_col ? r_ys[r_corner[0]] : r_xs[r_corner[1]];
    assign w_prod  = w_coef * w_coord;
    assign w_pm    = r_cnt - 3'd1;
    assign w_prow  = w_pm[2:1];
    assign w_pext  = RowW'(r_prod) >>> FRAC_BITS;

    assign w_ax = {i_item.a[31], i_item.a};
    assign w_ay = {i_item.b[31], i_item.b};
    assign w_cx = {i_item.c[31], i_item.c};
    assign w_dy = {i_item.d[31], i_item.d};

    assign w_rlx = 34'sd0 - 34'(r_ref[0]);
    assign w_rhx = 34'(r_ref[2]) - 34'(r_ref[0]);
    assign w_rly = 34'sd0 - 34'(r_ref[1]);
    assign w_rhy = 34'(r_ref[3]) - 34'(r_ref[1]);
    assign w_hit = !r_flt
                && meet(34'(r_minx), 34'(r_maxx), w_rlx, w_rhx)
                && meet(34'(r_miny), 34'(r_maxy), w_rly, w_rhy);

    assign w_free = !r_res_v || i_res_pop;

    assign o_pop       = (r_state == S_IDLE) && i_valid;
    assign o_div.start = (r_state == S_CHK && r_acc[2] != '0)
                      || (r_state == S_DX && i_div.done);
    assign o_div.num   = (r_state == S_CHK) ? r_acc[0] : r_acc[1];
    assign o_div.den   = r_acc[2];

    assign o_res_valid = r_res_v;
    assign o_hit       = r_hit;
    assign o_fault     = r_fault;

    always_ff @(posedge i_clk) begin
        // datapath
        case (r_state)
            S_IDLE: begin
                if (i_valid && i_item.op == OP_TEST) begin
                    r_xs[0]  <= sat33(33'sd0 - w_ax);
                    r_xs[1]  <= sat33(w_cx - w_ax);
                    r_ys[0]  <= sat33(33'sd0 - w_ay);
                    r_ys[1]  <= sat33(w_dy - w_ay);
                    r_corner <= 2'd0;
                    r_first  <= 1'b1;
                    r_flt    <= 1'b0;
                    r_cnt    <= 3'd0;
                    r_acc[0] <= RowW'(r_rows[2]);
                    r_acc[1] <= RowW'(r_rows[5]);
                    r_acc[2] <= RowW'(r_rows[8]);
                end
            end
            S_MUL: begin
                if (r_cnt != 3'd6) r_prod <= w_prod;
                if (r_cnt != 3'd0) r_acc[w_prow] <= r_acc[w_prow] + w_pext;
                r_cnt <= r_cnt + 3'd1;
            end
            S_CHK: begin
                if (r_acc[2] == '0) r_flt <= 1'b1;
            end
            S_DX: begin
                if (i_div.done) r_qx <= i_div.q;
            end
            S_DY: begin
                if (i_div.done) begin
                    r_first <= 1'b0;
                    if (r_first || r_qx < r_minx)     r_minx <= r_qx;
                    if (r_first || r_qx > r_maxx)     r_maxx <= r_qx;
                    if (r_first || i_div.q < r_miny)  r_miny <= i_div.q;
                    if (r_first || i_div.q > r_maxy)  r_maxy <= i_div.q;
                end
            end
            S_NEXT: begin
                r_corner <= r_corner + 2'd1;
                r_cnt    <= 3'd0;
                r_acc[0] <= RowW'(r_rows[2]);
                r_acc[1] <= RowW'(r_rows[5]);
                r_acc[2] <= RowW'(r_rows[8]);
            end
            default: begin
            end
        endcase

        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_res_v <= 1'b0;
            r_hit   <= 1'b0;
            r_fault <= 1'b0;
            for (int k = 0; k < 4; k++) r_ref[k] <= 32'sd0;
            for (int k = 0; k < 9; k++) begin
                r_rows[k] <= (k == 0 || k == 4 || k == 8) ? One : 32'sd0;
            end
        end else begin
            if (i_res_pop && r_state != S_FIN) r_res_v <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        case (i_item.op)
                            OP_BOX: begin
                                r_ref[0] <= i_item.a;
                                r_ref[1] <= i_item.b;
                                r_ref[2] <= i_item.c;
                                r_ref[3] <= i_item.d;
                            end
                            OP_ROWX: begin
                                r_rows[0] <= i_item.a;
                                r_rows[1] <= i_item.b;
                                r_rows[2] <= i_item.c;
                            end
                            OP_ROWY: begin
                                r_rows[3] <= i_item.a;
                                r_rows[4] <= i_item.b;
                                r_rows[5] <= i_item.c;
                            end
                            OP_ROWW: begin
                                r_rows[6] <= i_item.a;
                                r_rows[7] <= i_item.b;
                                r_rows[8] <= i_item.c;
                            end
                            OP_TEST: r_state <= S_MUL;
                            default: begin
                            end
                        endcase
                    end
                end
                S_MUL:  if (r_cnt == 3'd6) r_state <= S_CHK;
                S_CHK:  r_state <= (r_acc[2] == '0) ? S_NEXT : S_DX;
                S_DX:   if (i_div.done) r_state <= S_DY;
                S_DY:   if (i_div.done) r_state <= S_NEXT;
                S_NEXT: r_state <= (r_corner == 2'd3) ? S_FIN : S_MUL;
                S_FIN: begin
                    // hold until the result register frees up
                    if (w_free) begin
                        r_res_v <= 1'b1;
                        r_hit   <= w_hit;
                        r_fault <= r_flt;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// ============================================================================
// tb_top
// Checks the transformed box overlap test with directed and random words.
// Loads and tests go in through the push/full side. A scoreboard class
// predicts hit and fault in fixed point and compares each popped result.
// ============================================================================
module tb_top;
    import tbo_pkg::*;

    localparam int FRAC    = 16;
    localparam int LATENCY = 400;
    localparam longint CYCLE_LIMIT = 1200000;

    typedef struct packed {
        logic hit;
        logic fault;
    } t_verdict;

    class overlap_scoreboard;
        logic signed [31:0] ref_box[4];
        logic signed [31:0] rows[9];
        t_verdict           pending[$];
        int                 errors;
        int                 checked;

        function new();
            ref_box = '{default: '0};
            rows    = '{default: '0};
            rows[0] = 32'sd1 <<< FRAC;
            rows[4] = 32'sd1 <<< FRAC;
            rows[8] = 32'sd1 <<< FRAC;
            errors  = 0;
            checked = 0;
        endfunction

        function longint clamp32(longint v);
            if (v > 64'sd2147483647) return 64'sd2147483647;
            if (v < -64'sd2147483648) return -64'sd2147483648;
            return v;
        endfunction

        // arithmetic shift rounds toward minus infinity
        function longint row_sum(int r, longint x, longint y);
            longint pa, pb;
            pa = longint'(rows[r*3]) * x;
            pb = longint'(rows[r*3+1]) * y;
            return (pa >>> FRAC) + (pb >>> FRAC) + longint'(rows[r*3+2]);
        endfunction

        function longint quotient(longint num, longint den);
            logic        neg;
            logic [127:0] n, d, q;
            neg = (num < 0) != (den < 0);
            n = (num < 0) ? 128'(-num) : 128'(num);
            d = (den < 0) ? 128'(-den) : 128'(den);
            q = (n << FRAC) / d;
            if (neg) begin
                if (q > 128'd2147483648) q = 128'd2147483648;
                return -longint'(q[63:0]);
            end
            if (q > 128'd2147483647) q = 128'd2147483647;
            return longint'(q[63:0]);
        endfunction

        function bit spans_meet(longint a0, longint a1, longint b0, longint b1);
            longint t;
            if (a0 > a1) begin t = a0; a0 = a1; a1 = t; end
            if (b0 > b1) begin t = b0; b0 = b1; b1 = t; end
            return ((a0 > b0) ? a0 : b0) <= ((a1 < b1) ? a1 : b1);
        endfunction

        function void note_word(t_op op, logic signed [31:0] a, logic signed [31:0] b,
                                logic signed [31:0] c, logic signed [31:0] d);
            longint xs[2], ys[2], xw, yw, ww, qx, qy;
            longint minx, maxx, miny, maxy;
            bit flt, first;
            t_verdict v;
            minx = 0; maxx = 0; miny = 0; maxy = 0;
            flt = 0; first = 1;
            case (op)
                OP_BOX: begin
                    ref_box[0] = a; ref_box[1] = b; ref_box[2] = c; ref_box[3] = d;
                end
                OP_ROWX, OP_ROWY, OP_ROWW: begin
                    rows[(op-1)*3] = a; rows[(op-1)*3+1] = b; rows[(op-1)*3+2] = c;
                end
                OP_TEST: begin
                    xs[0] = clamp32(-longint'(a));
                    xs[1] = clamp32(longint'(c) - longint'(a));
                    ys[0] = clamp32(-longint'(b));
                    ys[1] = clamp32(longint'(d) - longint'(b));
                    for (int i = 0; i < 2; i++) begin
                        for (int j = 0; j < 2; j++) begin
                            xw = row_sum(0, xs[i], ys[j]);
                            yw = row_sum(1, xs[i], ys[j]);
                            ww = row_sum(2, xs[i], ys[j]);
                            if (ww == 0) begin
                                flt = 1;
                                continue;
                            end
                            qx = quotient(xw, ww);
                            qy = quotient(yw, ww);
                            if (first) begin
                                minx = qx; maxx = qx; miny = qy; maxy = qy; first = 0;
                            end else begin
                                if (qx < minx) minx = qx;
                                if (qx > maxx) maxx = qx;
                                if (qy < miny) miny = qy;
                                if (qy > maxy) maxy = qy;
                            end
                        end
                    end
                    v.fault = flt;
                    v.hit = flt ? 1'b0 :
                        spans_meet(minx, maxx, -longint'(ref_box[0]),
                                   longint'(ref_box[2]) - longint'(ref_box[0])) &&
                        spans_meet(miny, maxy, -longint'(ref_box[1]),
                                   longint'(ref_box[3]) - longint'(ref_box[1]));
                    pending.push_back(v);
                end
                default: ;
            endcase
        endfunction

        task report_mismatch(string what, logic want, logic got);
            errors++;
            $display("MISMATCH %s: expected %b got %b (result %0d)", what, want, got, checked);
        endtask

        task check_result(logic hit, logic fault);
            t_verdict want;
            checked++;
            if (pending.size() == 0) begin
                report_mismatch("result with nothing expected", 0, hit);
                return;
            end
            want = pending.pop_front();
            if (hit !== want.hit) report_mismatch("hit", want.hit, hit);
            if (fault !== want.fault) report_mismatch("fault", want.fault, fault);
        endtask
    endclass

    logic               i_clk = 0;
    logic               i_rst_n = 0;
    logic               push = 0;
    logic               pop = 0;
    logic [2:0]         i_func = '0;
    logic signed [31:0] i_word_a = '0, i_word_b = '0, i_word_c = '0, i_word_d = '0;
    logic               full, empty, o_hit, o_fault;

    overlap_scoreboard scb = new();
    int     send_idle = 0;
    int     pop_stall = 0;
    longint cycles = 0;
    int     words_sent = 0;

    transformed_box_overlap_test DUT (
        .i_clk, .i_rst_n, .push, .full, .i_func, .i_word_a, .i_word_b,
        .i_word_c, .i_word_d, .empty, .pop, .o_hit, .o_fault
    );

    always begin
        #2 i_clk = 1;
        #2 i_clk = 0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("** transformed_box_overlap_test: FAILED **");
            $finish;
        end
    end

    // check on the rising edge, choose the next pop at the falling edge
    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty) scb.check_result(o_hit, o_fault);
    end

    always @(negedge i_clk) begin
        pop <= i_rst_n && ($urandom_range(99) >= pop_stall);
    end

    // push stays high after the accepting edge so that words can follow
    // back to back; an idle cycle or a drain drops it
    task automatic send_word(t_op op, logic signed [31:0] a, logic signed [31:0] b,
                             logic signed [31:0] c, logic signed [31:0] d);
        while ($urandom_range(99) < send_idle) begin
            push <= 0;
            @(negedge i_clk);
        end
        push <= 1; i_func <= op;
        i_word_a <= a; i_word_b <= b; i_word_c <= c; i_word_d <= d;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        scb.note_word(op, a, b, c, d);
        words_sent++;
        @(negedge i_clk);
    endtask

    task automatic drain();
        push <= 0;
        while (scb.pending.size() != 0) @(negedge i_clk);
        repeat (LATENCY) @(negedge i_clk);
    endtask

    function automatic logic signed [31:0] rnd_fix(int range_bits);
        logic signed [31:0] v;
        v = $urandom;
        return v >>> (32 - range_bits);
    endfunction

    task automatic random_word();
        int pick;
        logic signed [31:0] a, b, c, d;
        pick = $urandom_range(99);
        if (pick < 8) begin
            // full random noise, extreme words included
            send_word(t_op'($urandom_range(7)), $urandom, $urandom, $urandom, $urandom);
        end else if (pick < 22) begin
            a = rnd_fix(20); b = rnd_fix(20); c = rnd_fix(20); d = rnd_fix(20);
            send_word(OP_BOX, a, b, c, d);
        end else if (pick < 36) begin
            a = rnd_fix(19); b = rnd_fix(17); c = rnd_fix(22);
            if ($urandom_range(3) == 0) c = 0;
            send_word(t_op'($urandom_range(OP_ROWW, OP_ROWX)), a, b, c, $urandom);
        end else begin
            a = rnd_fix(21); b = rnd_fix(21); c = rnd_fix(21); d = rnd_fix(21);
            send_word(OP_TEST, a, b, c, d);
        end
    endtask

    localparam logic signed [31:0] ONE = 32'sh0001_0000;
    localparam logic signed [31:0] MAXW = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] MINW = 32'sh8000_0000;

    initial begin
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1;
        @(negedge i_clk);

        // directed: identity, touching, extremes, zero w, unused funcs
        send_word(OP_TEST, 0, 0, 0, 0);
        send_word(OP_BOX, ONE, ONE, 2*ONE, 2*ONE);
        send_word(OP_TEST, -ONE, -ONE, 0, 0);
        send_word(OP_TEST, -3*ONE, 0, 2*ONE, ONE);
        send_word(OP_TEST, -4*ONE, 0, 2*ONE, ONE);
        send_word(OP_TEST, MINW, MINW, MAXW, MAXW);
        send_word(OP_TEST, MAXW, MAXW, MINW, MINW);
        send_word(3'd5, $urandom, $urandom, $urandom, $urandom);
        send_word(3'd6, $urandom, $urandom, $urandom, $urandom);
        send_word(3'd7, $urandom, $urandom, $urandom, $urandom);
        send_word(OP_ROWW, 0, 0, 0, MINW);
        send_word(OP_TEST, ONE, ONE, ONE, ONE);
        send_word(OP_ROWW, ONE, 0, 0, MAXW);
        send_word(OP_TEST, -ONE, -ONE, 2*ONE, 2*ONE);
        send_word(OP_ROWW, 0, 0, 1, 0);
        send_word(OP_ROWX, MAXW, MINW, MAXW, 0);
        send_word(OP_ROWY, MINW, MAXW, MINW, 0);
        send_word(OP_TEST, MINW, MAXW, MAXW, MINW);
        send_word(OP_ROWW, MINW, MAXW, ONE, 0);
        send_word(OP_TEST, -ONE, -2*ONE, 3*ONE, ONE);
        send_word(OP_BOX, MAXW, MINW, MINW, MAXW);
        send_word(OP_TEST, 0, 0, ONE, ONE);
        drain();

        for (int phase = 0; phase < 4; phase++) begin
            send_idle = (phase == 1 || phase == 3) ? ((phase == 3) ? 33 : 81) : 0;
            pop_stall = (phase == 2 || phase == 3) ? ((phase == 3) ? 33 : 81) : 0;
            if (phase == 0) begin
                send_word(OP_ROWX, ONE, 0, 0, 0);
                send_word(OP_ROWY, 0, ONE, 0, 0);
                send_word(OP_ROWW, 0, 0, ONE, 0);
            end
            for (int n = 0; n < 132; n++) begin
                random_word();
                // let everything come back once mid-phase
                if (n == 66) drain();
            end
            drain();
        end

        $display("ran %0d words, %0d results checked over four idle/stall mixes",
                 words_sent, scb.checked);
        if (scb.errors == 0 && scb.pending.size() == 0)
            $display("** transformed_box_overlap_test: PASSED **");
        else
            $display("** transformed_box_overlap_test: FAILED **");
        $finish;
    end
endmodule
